/* rtl/depth_pixel_backprojection_core_macros.svh */
// Assertion helpers for the RTL.
`ifndef DEPTH_PIXEL_BACKPROJECTION_CORE_MACROS_SVH
`define DEPTH_PIXEL_BACKPROJECTION_CORE_MACROS_SVH

`ifndef SYNTHESIS

// checked only out of reset
`define DPB_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: check failed");

// checked on every edge, reset included
`define DPB_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");

`else

`define DPB_ASSERT(lbl, clk, rstn, prop)
`define DPB_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

/* rtl/dpb_pkg.sv */
package dpb_pkg;

    localparam int COORD_BITS_DEF      = 12;
    localparam int POINT_FRAC_BITS_DEF = 16;

    localparam int DEPTH_W  = 16;
    localparam int COLOR_W  = 8;
    localparam int RGB_W    = 3 * COLOR_W;
    localparam int INV_W    = 24;
    localparam int CENTER_W = 16;
    localparam int POINT_W  = 24;
    localparam int INV_SPLIT = 12;   // reciprocal cut into two 12-bit halves
    localparam int CENTER_FRAC = 4;  // Q12.4 centre
    localparam int PROJ_SHIFT  = 28; // 4 centre frac + 24 reciprocal frac

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    // pipeline: offset/z-product, z-sat/p1, partial products, output
    localparam int NUM_STAGES = 4;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_INV_DEPTH_SCALE = 3'd0,
        REG_CENTER_X        = 3'd1,
        REG_CENTER_Y        = 3'd2,
        REG_INV_FOCAL_X     = 3'd3,
        REG_INV_FOCAL_Y     = 3'd4,
        REG_NEGATE_Y        = 3'd5,
        REG_SUBSAMPLE_ON    = 3'd6
    } cfg_idx_t;

    localparam logic [INV_W-1:0]    RST_INV_DEPTH_SCALE = 24'd16777;
    localparam logic [CENTER_W-1:0] RST_CENTER_X        = 16'd5120;
    localparam logic [CENTER_W-1:0] RST_CENTER_Y        = 16'd3840;
    localparam logic [INV_W-1:0]    RST_INV_FOCAL_X     = 24'd32768;
    localparam logic [INV_W-1:0]    RST_INV_FOCAL_Y     = 24'd32768;
    localparam logic                RST_NEGATE_Y        = 1'b1;
    localparam logic                RST_SUBSAMPLE_ON    = 1'b1;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;   // stage k takes new data this cycle
    } pipe_ctl_t;

endpackage

/* rtl/depth_pixel_backprojection_core.sv */
// Pinhole back-projection of a depth pixel stream. Each s_ transaction carries
// one pixel (row, column, raw depth, BGR bytes); a pixel with zero depth, or
// with an odd row or column while subsampling is on, is consumed and gives
// nothing. Every other pixel gives one m_ transaction holding the 3D point
// (x, y signed and z unsigned, POINT_FRAC_BITS fraction bits, saturated to 24
// bits) with its colour bytes. Throughput is one pixel per clock unless m_tready
// stalls the output. Each pixel passes through four register stages (depth
// product and centre offset, z clamp with the offset multiply, the two
// half-width reciprocal multiplies, then combine and clamp), and m_tvalid
// is the valid bit of the last. m_tready feeds back through each stage's ready
// combinationally to s_tready, and a dropped pixel leaves a hole that the
// following pixels close up under stall.
// Configuration registers are written through cfg_we/cfg_addr/cfg_wdata and
// must only change while no pixel is in flight.
module depth_pixel_backprojection_core #(
    parameter int COORD_BITS      = dpb_pkg::COORD_BITS_DEF,
    parameter int POINT_FRAC_BITS = dpb_pkg::POINT_FRAC_BITS_DEF,
    localparam int S_TDATA_W = ((2 * COORD_BITS + 40 + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // pixel input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [pixel_row, pixel_col, depth_value(16), blue, green, red] from bit 0 up
    input  logic [S_TDATA_W-1:0]            s_tdata,
    // point output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [point_x(24), point_y(24), point_z(24), out_blue, out_green, out_red]
    output logic [95:0]                     m_tdata,
    // register writes
    input  logic                            cfg_we,
    input  logic [dpb_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [dpb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import dpb_pkg::*;

    localparam int ZPROD_W = DEPTH_W + INV_W;
    localparam int ZSHIFT  = INV_W - POINT_FRAC_BITS;
    localparam int DEPTH_LSB = 2 * COORD_BITS;
    localparam int RGB_LSB   = DEPTH_LSB + DEPTH_W;

    // ---------------- configuration registers ----------------
    logic [INV_W-1:0]    inv_depth_scale_reg;
    logic [CENTER_W-1:0] center_x_reg, center_y_reg;
    logic [INV_W-1:0]    inv_focal_x_reg, inv_focal_y_reg;
    logic                negate_y_reg, subsample_on_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_depth_scale_reg <= RST_INV_DEPTH_SCALE;
            center_x_reg        <= RST_CENTER_X;
            center_y_reg        <= RST_CENTER_Y;
            inv_focal_x_reg     <= RST_INV_FOCAL_X;
            inv_focal_y_reg     <= RST_INV_FOCAL_Y;
            negate_y_reg        <= RST_NEGATE_Y;
            subsample_on_reg    <= RST_SUBSAMPLE_ON;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_addr))
                REG_INV_DEPTH_SCALE: inv_depth_scale_reg <= cfg_wdata[INV_W-1:0];
                REG_CENTER_X:        center_x_reg        <= cfg_wdata[CENTER_W-1:0];
                REG_CENTER_Y:        center_y_reg        <= cfg_wdata[CENTER_W-1:0];
                REG_INV_FOCAL_X:     inv_focal_x_reg     <= cfg_wdata[INV_W-1:0];
                REG_INV_FOCAL_Y:     inv_focal_y_reg     <= cfg_wdata[INV_W-1:0];
                REG_NEGATE_Y:        negate_y_reg        <= cfg_wdata[0];
                REG_SUBSAMPLE_ON:    subsample_on_reg    <= cfg_wdata[0];
                default: ;           // unused index: ignored
            endcase
        end
    end

    // ---------------- input unpack and pixel filter ----------------
    logic [COORD_BITS-1:0] pixel_row, pixel_col;
    logic [DEPTH_W-1:0]    depth_value;
    logic [RGB_W-1:0]      rgb_in;
    logic                  keep;

    assign pixel_row   = s_tdata[COORD_BITS-1:0];
    assign pixel_col   = s_tdata[DEPTH_LSB-1:COORD_BITS];
    assign depth_value = s_tdata[DEPTH_LSB +: DEPTH_W];
    assign rgb_in      = s_tdata[RGB_LSB +: RGB_W];

    // zero depth is no measurement; subsampling keeps even row and column only
    assign keep = (depth_value != '0) &&
                  !(subsample_on_reg && (pixel_row[0] || pixel_col[0]));

    // ---------------- handshake and stage enables ----------------
    pipe_ctl_t ctl;

    dpb_pipe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .keep     (keep),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctl      (ctl)
    );

    // ---------------- depth path ----------------
    // stage 0: raw product, Q.24
    // stage 1: truncate to POINT_FRAC_BITS and clamp to 24 bits
    logic [ZPROD_W-1:0]     zprod_reg;
    logic [ZPROD_W-1:0]     zsh;
    logic [POINT_W-1:0]     z_sat;
    logic [POINT_W-1:0]     z_reg [1:NUM_STAGES-1];
    logic [RGB_W-1:0]       rgb_reg [0:NUM_STAGES-1];

    assign zsh   = zprod_reg >> ZSHIFT;
    assign z_sat = (|zsh[ZPROD_W-1:POINT_W]) ? {POINT_W{1'b1}} : zsh[POINT_W-1:0];

    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            zprod_reg  <= (ZPROD_W)'(depth_value) * (ZPROD_W)'(inv_depth_scale_reg);
            rgb_reg[0] <= rgb_in;
        end
        if (ctl.load[1]) begin
            z_reg[1]   <= z_sat;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (ctl.load[k]) begin
                rgb_reg[k] <= rgb_reg[k-1];
            end
        end
        for (int k = 2; k < NUM_STAGES; k++) begin
            if (ctl.load[k]) begin
                z_reg[k] <= z_reg[k-1];
            end
        end
    end

    // ---------------- lateral axes ----------------
    logic [POINT_W-1:0] point_x, point_y;

    dpb_axis_proj #(.COORD_BITS(COORD_BITS)) u_axis_x (
        .aclk      (aclk),
        .ctl       (ctl),
        .coord     (pixel_col),
        .center    (center_x_reg),
        .inv_focal (inv_focal_x_reg),
        .flip      (1'b0),
        .z_sat     (z_sat),
        .point     (point_x)
    );

    dpb_axis_proj #(.COORD_BITS(COORD_BITS)) u_axis_y (
        .aclk      (aclk),
        .ctl       (ctl),
        .coord     (pixel_row),
        .center    (center_y_reg),
        .inv_focal (inv_focal_y_reg),
        .flip      (negate_y_reg),
        .z_sat     (z_sat),
        .point     (point_y)
    );

    assign m_tdata = {rgb_reg[NUM_STAGES-1], z_reg[NUM_STAGES-1], point_y, point_x};

endmodule

/* rtl/dpb_pipe_ctrl.sv */
`include "depth_pixel_backprojection_core_macros.svh"

module dpb_pipe_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              keep,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output dpb_pkg::pipe_ctl_t ctl
);
    import dpb_pkg::*;

    logic [NUM_STAGES-1:0] vld_reg, vld_next;
    logic [NUM_STAGES-1:0] rdy;

    // a stage may load when empty or when the stage after it moves on
    always_comb begin
        rdy[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    always_comb begin
        vld_next[0] = rdy[0] ? (s_tvalid && keep) : vld_reg[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[NUM_STAGES-1];
    assign ctl.load = rdy;

    `DPB_ASSERT(a_free_out_frees_in, aclk, aresetn, m_tready |-> s_tready)
    `DPB_ASSERT(a_stall_keeps_first, aclk, aresetn, (vld_reg[0] && !rdy[1]) |=> vld_reg[0])
    `DPB_ASSERT(a_drop_no_entry, aclk, aresetn, (s_tready && !keep) |=> !vld_reg[0])
    `DPB_ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> !m_tvalid)

endmodule

/* rtl/dpb_axis_proj.sv */
module dpb_axis_proj #(
    parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEF
) (
    input  logic                            aclk,
    input  dpb_pkg::pipe_ctl_t              ctl,
    input  logic [COORD_BITS-1:0]           coord,
    input  logic [dpb_pkg::CENTER_W-1:0]    center,
    input  logic [dpb_pkg::INV_W-1:0]       inv_focal,
    input  logic                            flip,
    input  logic [dpb_pkg::POINT_W-1:0]     z_sat,     // aligned with stage 1 load
    output logic [dpb_pkg::POINT_W-1:0]     point
);
    import dpb_pkg::*;

    localparam int SH_W  = COORD_BITS + CENTER_FRAC;
    localparam int OFF_W = (SH_W > CENTER_W) ? SH_W : CENTER_W;
    localparam int P1_W  = OFF_W + POINT_W;
    localparam int PP_W  = P1_W + INV_SPLIT;
    localparam int SUM_W = PP_W + 1;
    localparam int HI_SH = PROJ_SHIFT - INV_SPLIT;
    localparam int Q_W   = SUM_W - HI_SH;

    // stage 0: offset magnitude and sign
    logic [OFF_W:0]   diff;
    logic [OFF_W:0]   diff_abs;
    logic [OFF_W-1:0] mag_reg;
    logic             neg0_reg, neg1_reg, neg2_reg;

    assign diff     = (OFF_W + 1)'({coord, {CENTER_FRAC{1'b0}}}) - (OFF_W + 1)'(center);
    assign diff_abs = diff[OFF_W] ? ((OFF_W + 1)'(0) - diff) : diff;

    // stage 1: |d| * z
    logic [P1_W-1:0] p1_reg;
    // stage 2: split products against the reciprocal halves
    logic [PP_W-1:0] hi_reg, lo_reg;
    // stage 3: combine, shift, sign and clamp
    logic [SUM_W-1:0]   sum;
    logic [Q_W-1:0]     q;
    logic               ovf;
    logic [POINT_W-1:0] point_next, point_reg;

    always_comb begin
        sum = (SUM_W)'(hi_reg) + (SUM_W)'(lo_reg >> INV_SPLIT);
        q   = sum[SUM_W-1:HI_SH];
        ovf = |q[Q_W-1:POINT_W-1];
        if (neg2_reg) begin
            point_next = ovf ? {1'b1, {(POINT_W-1){1'b0}}}
                             : POINT_W'(0) - {1'b0, q[POINT_W-2:0]};
        end else begin
            point_next = ovf ? {1'b0, {(POINT_W-1){1'b1}}} : {1'b0, q[POINT_W-2:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            mag_reg  <= diff_abs[OFF_W-1:0];
            neg0_reg <= diff[OFF_W] ^ flip;
        end
        if (ctl.load[1]) begin
            p1_reg   <= (P1_W)'(mag_reg) * (P1_W)'(z_sat);
            neg1_reg <= neg0_reg;
        end
        if (ctl.load[2]) begin
            hi_reg   <= (PP_W)'(p1_reg) * (PP_W)'(inv_focal[INV_W-1:INV_SPLIT]);
            lo_reg   <= (PP_W)'(p1_reg) * (PP_W)'(inv_focal[INV_SPLIT-1:0]);
            neg2_reg <= neg1_reg;
        end
        if (ctl.load[3]) begin
            point_reg <= point_next;
        end
    end

    assign point = point_reg;

endmodule
